// ===== design/ps2rf_pkg.sv =====
// Shared types and constants for the PS/2 port register block.
package ps2rf_pkg;

  localparam int unsigned FIFO_DEPTH_DEF = 256;

  localparam logic [1:0] MODE_READ  = 2'd0;
  localparam logic [1:0] MODE_WRITE = 2'd1;
  localparam logic [1:0] MODE_RX    = 2'd2;

  localparam logic [2:0] ADDR_DATA = 3'd0;
  localparam logic [2:0] ADDR_CTRL = 3'd4;

  localparam logic [3:0] ACCESS_WORD = 4'd4;

  typedef struct packed {
    logic [1:0] mode;
    logic [2:0] address;
    logic [3:0] access_size;
    logic [7:0] write_data;
    logic [7:0] rx_byte;
  } ps2rf_in_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        access_ok;
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        irq_level;
  } ps2rf_out_t;

  typedef struct packed {
    logic load;
    logic exec;
  } ps2rf_cmd_t;

endpackage

// ===== design/ps2rf_ctrl.sv =====
// Controller state machine that sequences capture, execution and result handoff.
module ps2rf_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output ps2rf_pkg::ps2rf_cmd_t cmd_o
);
  import ps2rf_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   accept;

  assign in_ready_o  = (state_q == ST_IDLE) && (!out_valid_q || out_ready_i);
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign cmd_o.load  = accept;
  assign cmd_o.exec  = (state_q == ST_EXEC);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (out_ready_i) begin
            out_valid_q <= 1'b0;
          end
          if (accept) begin
            state_q <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          out_valid_q <= 1'b1;
          state_q     <= ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== design/ps2rf_datapath.sv =====
// Datapath with the word register, receive FIFO, interrupt flags and result register.
module ps2rf_datapath #(
  parameter int unsigned FifoDepth = ps2rf_pkg::FIFO_DEPTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  ps2rf_pkg::ps2rf_cmd_t cmd_i,
  input  ps2rf_pkg::ps2rf_in_t  in_word_i,
  output ps2rf_pkg::ps2rf_out_t out_word_o
);
  import ps2rf_pkg::*;

  localparam int unsigned PtrW = (FifoDepth > 1) ? $clog2(FifoDepth) : 1;
  localparam int unsigned CntW = $clog2(FifoDepth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(FifoDepth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(FifoDepth);

  logic [7:0] mem_q [FifoDepth];
  logic [7:0] mem_rd_q;

  ps2rf_in_t  item_q;
  ps2rf_out_t out_q, out_d;

  logic [PtrW-1:0] rptr_q, rptr_d, wptr_q, wptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            ien_q, ien_d, pend_q, pend_d, line_q, line_d;
  logic            push;
  logic [15:0]     cnt_ext;

  assign cnt_ext    = 16'(cnt_q);
  assign out_word_o = out_q;

  always_comb begin
    rptr_d = rptr_q;
    wptr_d = wptr_q;
    cnt_d  = cnt_q;
    ien_d  = ien_q;
    pend_d = pend_q;
    line_d = line_q;
    push   = 1'b0;
    out_d  = '0;
    unique case (item_q.mode)
      MODE_READ: begin
        if (item_q.access_size == ACCESS_WORD) begin
          out_d.access_ok = 1'b1;
          if (item_q.address == ADDR_DATA) begin
            line_d = 1'b0;
            if (cnt_q != '0) begin
              out_d.read_data = {cnt_ext, 1'b1, 7'b0, mem_rd_q};
              rptr_d = (rptr_q == PtrLast) ? '0 : rptr_q + 1'b1;
              cnt_d  = cnt_q - 1'b1;
            end
          end else if (item_q.address == ADDR_CTRL) begin
            out_d.read_data = {23'b0, pend_q, 7'b0, ien_q};
          end
        end
      end
      MODE_WRITE: begin
        if (item_q.access_size == ACCESS_WORD) begin
          if (item_q.address == ADDR_DATA) begin
            out_d.access_ok = 1'b1;
            out_d.tx_valid  = 1'b1;
            out_d.tx_byte   = item_q.write_data;
          end else if (item_q.address == ADDR_CTRL) begin
            out_d.access_ok = 1'b1;
            ien_d = item_q.write_data[0];
          end
        end
      end
      MODE_RX: begin
        if (cnt_q < CntFull) begin
          push   = 1'b1;
          wptr_d = (wptr_q == PtrLast) ? '0 : wptr_q + 1'b1;
          cnt_d  = cnt_q + 1'b1;
        end
        if (ien_q) begin
          pend_d = 1'b1;
          line_d = 1'b1;
        end
      end
      default: begin
      end
    endcase
    out_d.irq_level = line_d;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && push) begin
      mem_q[wptr_q] <= item_q.rx_byte;
    end
    mem_rd_q <= mem_q[rptr_q];
    if (cmd_i.load) begin
      item_q <= in_word_i;
    end
    if (cmd_i.exec) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rptr_q <= '0;
      wptr_q <= '0;
      cnt_q  <= '0;
      ien_q  <= 1'b0;
      pend_q <= 1'b0;
      line_q <= 1'b0;
    end else if (cmd_i.exec) begin
      rptr_q <= rptr_d;
      wptr_q <= wptr_d;
      cnt_q  <= cnt_d;
      ien_q  <= ien_d;
      pend_q <= pend_d;
      line_q <= line_d;
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntFull)
    else $error("FIFO count exceeds depth");

  a_empty_ptrs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0) |-> (rptr_q == wptr_q))
    else $error("Empty FIFO with unequal pointers");

  a_pend_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |=> pend_q)
    else $error("Pending flag cleared without reset");

  a_line_needs_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    line_q |-> pend_q)
    else $error("Interrupt line high without pending flag");
`endif

endmodule

// ===== design/ps2_port_register_fifo.sv =====
// Top level of the PS/2 port register block with receive FIFO.
// The edge that accepts an input word captures it and enters the execute state, which then registers the result word.
// A new input word is not taken during the execute state, which waits on
// the registered read port of the receive FIFO memory, nor while a result is held unaccepted.
// Reset clears pointers, count, interrupt flags and handshake state at once;
// the FIFO storage itself is not cleared and there is no clearing pass.
module ps2_port_register_fifo #(
  parameter int unsigned FifoDepth = ps2rf_pkg::FIFO_DEPTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  ps2rf_pkg::ps2rf_in_t  in_word_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output ps2rf_pkg::ps2rf_out_t out_word_o
);
  import ps2rf_pkg::*;

  ps2rf_cmd_t cmd;

  ps2rf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  ps2rf_datapath #(
    .FifoDepth (FifoDepth)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .in_word_i  (in_word_i),
    .out_word_o (out_word_o)
  );

endmodule

// ===== test/tb_ps2_port_register_fifo.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the PS/2 port register block with its receive FIFO.
module tb_ps2_port_register_fifo;
  import ps2rf_pkg::*;

  localparam logic [1:0] MODE_NONE = 2'd3;
  localparam logic [2:0] ADDR_ODD = 3'd7;
  localparam logic [2:0] ADDR_GAP = 3'd3;
  localparam logic [3:0] ACCESS_NONE = 4'd0;
  localparam logic [3:0] ACCESS_BYTE = 4'd1;
  localparam logic [3:0] ACCESS_DWORD = 4'd8;
  localparam logic [3:0] ACCESS_MAX = 4'd15;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned FILL_BURST = FIFO_DEPTH_DEF + 6;
  localparam int unsigned RANDOM_WORDS = 130;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  ps2rf_in_t in_word_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  ps2rf_out_t out_word_o;

  ps2rf_in_t port_words[$];
  ps2rf_out_t expected_results[$];
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned mismatch_count = 0;
  logic in_taken = 1'b0;
  logic hold_go = 1'b0;
  logic holding = 1'b0;

  logic [7:0] rx_mem [FIFO_DEPTH_DEF];
  int unsigned rx_head = 0;
  int unsigned rx_tail = 0;
  int unsigned rx_count = 0;
  logic irq_en = 1'b0;
  logic irq_pend = 1'b0;
  logic irq_line = 1'b0;

  ps2_port_register_fifo uut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .in_word_i(in_word_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_word_o(out_word_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic ps2rf_out_t predict_port(ps2rf_in_t w);
    ps2rf_out_t r;
    r = '0;
    case (w.mode)
      MODE_READ: begin
        if (w.access_size == ACCESS_WORD) begin
          r.access_ok = 1'b1;
          if (w.address == ADDR_DATA) begin
            irq_line = 1'b0;
            if (rx_count != 0) begin
              r.read_data = {16'(rx_count), 8'h80, rx_mem[rx_head]};
              rx_head = (rx_head + 1) % FIFO_DEPTH_DEF;
              rx_count = rx_count - 1;
            end
          end else if (w.address == ADDR_CTRL) begin
            r.read_data = {23'd0, irq_pend, 7'd0, irq_en};
          end
        end
      end
      MODE_WRITE: begin
        if (w.access_size == ACCESS_WORD) begin
          if (w.address == ADDR_DATA) begin
            r.access_ok = 1'b1;
            r.tx_valid = 1'b1;
            r.tx_byte = w.write_data;
          end else if (w.address == ADDR_CTRL) begin
            r.access_ok = 1'b1;
            irq_en = w.write_data[0];
          end
        end
      end
      MODE_RX: begin
        if (rx_count < FIFO_DEPTH_DEF) begin
          rx_mem[rx_tail] = w.rx_byte;
          rx_tail = (rx_tail + 1) % FIFO_DEPTH_DEF;
          rx_count = rx_count + 1;
        end
        if (irq_en) begin
          irq_pend = 1'b1;
          irq_line = 1'b1;
        end
      end
      default: begin
      end
    endcase
    r.irq_level = irq_line;
    return r;
  endfunction

  function automatic ps2rf_in_t random_port_word();
    ps2rf_in_t w;
    int unsigned pick;
    w.mode = 2'($urandom_range(3));
    w.address = 3'($urandom_range(7));
    w.access_size = 4'($urandom_range(15));
    w.write_data = 8'($urandom);
    w.rx_byte = 8'($urandom);
    pick = $urandom_range(99);
    if (pick < 35) begin
      w.mode = MODE_RX;
    end else if (pick < 65) begin
      w.mode = MODE_READ;
      w.address = ADDR_DATA;
      w.access_size = ACCESS_WORD;
    end else if (pick < 72) begin
      w.mode = MODE_READ;
      w.address = ADDR_CTRL;
      w.access_size = ACCESS_WORD;
    end else if (pick < 80) begin
      w.mode = MODE_WRITE;
      w.address = ADDR_DATA;
      w.access_size = ACCESS_WORD;
    end else if (pick < 88) begin
      w.mode = MODE_WRITE;
      w.address = ADDR_CTRL;
      w.access_size = ACCESS_WORD;
    end
    return w;
  endfunction

  task automatic push_word(logic [1:0] mode, logic [2:0] address, logic [3:0] access_size,
                           logic [7:0] write_data, logic [7:0] rx_byte);
    ps2rf_in_t w;
    w.mode = mode;
    w.address = address;
    w.access_size = access_size;
    w.write_data = write_data;
    w.rx_byte = rx_byte;
    port_words.push_back(w);
  endtask

  task automatic wait_drained();
    while (port_words.size() != 0 || in_valid_i || expected_results.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  task automatic run_random(int unsigned send_pct, int unsigned stall_pct, bit with_hold);
    send_idle_pct = send_pct;
    recv_stall_pct = stall_pct;
    repeat (RANDOM_WORDS) port_words.push_back(random_port_word());
    if (with_hold) begin
      hold_go = 1'b1;
    end
    wait_drained();
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t: mismatch on %s: got %h, expected %h", $realtime, what, got, want);
    mismatch_count = mismatch_count + 1;
  endtask

  always @(negedge clk_i) begin
    logic send;
    if (rst_ni && !(in_valid_i && !in_taken)) begin
      send = port_words.size() != 0 && $urandom_range(99) >= send_idle_pct;
      if (send) begin
        in_word_i <= port_words.pop_front();
      end
      in_valid_i <= send;
    end
  end

  always @(negedge clk_i) begin
    out_ready_i <= rst_ni && !holding && $urandom_range(99) >= recv_stall_pct;
  end

  initial begin
    wait (hold_go);
    @(negedge clk_i);
    holding <= 1'b1;
    repeat (HOLD_CYCLES) @(negedge clk_i);
    holding <= 1'b0;
  end

  always @(posedge clk_i) begin
    in_taken <= rst_ni && in_valid_i && in_ready_o;
    if (rst_ni && in_valid_i && in_ready_o) begin
      expected_results.push_back(predict_port(in_word_i));
    end
  end

  always @(posedge clk_i) begin
    ps2rf_out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected word", out_word_o.read_data, '0);
      end else begin
        want = expected_results.pop_front();
        if (out_word_o.read_data !== want.read_data) begin
          report_mismatch("read_data", out_word_o.read_data, want.read_data);
        end
        if (out_word_o.access_ok !== want.access_ok) begin
          report_mismatch("access_ok", 32'(out_word_o.access_ok), 32'(want.access_ok));
        end
        if (out_word_o.tx_valid !== want.tx_valid) begin
          report_mismatch("tx_valid", 32'(out_word_o.tx_valid), 32'(want.tx_valid));
        end
        if (out_word_o.tx_byte !== want.tx_byte) begin
          report_mismatch("tx_byte", 32'(out_word_o.tx_byte), 32'(want.tx_byte));
        end
        if (out_word_o.irq_level !== want.irq_level) begin
          report_mismatch("irq_level", 32'(out_word_o.irq_level), 32'(want.irq_level));
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    push_word(MODE_READ, ADDR_DATA, ACCESS_WORD, 8'h00, 8'h00);
    push_word(MODE_READ, ADDR_CTRL, ACCESS_WORD, 8'hFF, 8'hFF);
    push_word(MODE_WRITE, ADDR_CTRL, ACCESS_WORD, 8'hFF, 8'h00);
    push_word(MODE_RX, ADDR_DATA, ACCESS_WORD, 8'h00, 8'h00);
    push_word(MODE_RX, ADDR_ODD, ACCESS_MAX, 8'hFF, 8'hFF);
    push_word(MODE_READ, ADDR_CTRL, ACCESS_WORD, 8'h00, 8'h00);
    push_word(MODE_READ, ADDR_DATA, ACCESS_WORD, 8'h00, 8'h00);
    push_word(MODE_READ, ADDR_DATA, ACCESS_WORD, 8'h00, 8'h00);
    push_word(MODE_READ, ADDR_DATA, ACCESS_WORD, 8'h00, 8'h00);
    push_word(MODE_WRITE, ADDR_DATA, ACCESS_WORD, 8'hA5, 8'h00);
    push_word(MODE_WRITE, ADDR_DATA, ACCESS_WORD, 8'h5A, 8'hFF);
    push_word(MODE_WRITE, ADDR_CTRL, ACCESS_WORD, 8'hFE, 8'h00);
    push_word(MODE_RX, ADDR_DATA, ACCESS_NONE, 8'h00, 8'h3C);
    push_word(MODE_READ, ADDR_DATA, ACCESS_DWORD, 8'h00, 8'h00);
    push_word(MODE_WRITE, ADDR_DATA, ACCESS_BYTE, 8'h77, 8'h00);
    push_word(MODE_READ, ADDR_ODD, ACCESS_WORD, 8'h00, 8'h00);
    push_word(MODE_WRITE, ADDR_GAP, ACCESS_WORD, 8'h11, 8'h00);
    push_word(MODE_NONE, ADDR_CTRL, ACCESS_WORD, 8'hFF, 8'hFF);
    push_word(MODE_READ, ADDR_CTRL, ACCESS_MAX, 8'h00, 8'h00);
    push_word(MODE_READ, ADDR_CTRL, ACCESS_WORD, 8'h00, 8'h00);
    push_word(MODE_READ, ADDR_DATA, ACCESS_WORD, 8'h00, 8'h00);
    push_word(MODE_WRITE, ADDR_CTRL, ACCESS_NONE, 8'h01, 8'h00);
    wait_drained();

    run_random(0, 0, 1'b0);
    run_random(79, 0, 1'b0);
    run_random(0, 79, 1'b0);
    run_random(33, 33, 1'b1);

    // Fill the receive FIFO past its depth with interrupts on, then drain past empty.
    push_word(MODE_WRITE, ADDR_CTRL, ACCESS_WORD, 8'h01, 8'h00);
    repeat (FILL_BURST) push_word(MODE_RX, 3'($urandom), 4'($urandom), 8'($urandom),
                                  8'($urandom));
    push_word(MODE_READ, ADDR_CTRL, ACCESS_WORD, 8'h00, 8'h00);
    repeat (FILL_BURST) push_word(MODE_READ, ADDR_DATA, ACCESS_WORD, 8'($urandom),
                                  8'($urandom));
    wait_drained();

    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== ps2_port_register_fifo.f =====
design/ps2rf_pkg.sv
design/ps2rf_ctrl.sv
design/ps2rf_datapath.sv
design/ps2_port_register_fifo.sv
test/tb_ps2_port_register_fifo.sv
